// ----- rtl/core/ipd_pkg.sv -----
// Shared constants, types and helpers for the +IPD length-prefixed frame parser.
package ipd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PM_W     = 3;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned PREFIX_LEN = 5;

  // parser phase codes
  localparam logic [PHASE_W-1:0] PH_HUNT = 2'd0;
  localparam logic [PHASE_W-1:0] PH_LEN  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DATA = 2'd2;

  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] CHAR_I     = 8'h49;  // 'I'
  localparam logic [BYTE_W-1:0] CHAR_P     = 8'h50;  // 'P'
  localparam logic [BYTE_W-1:0] CHAR_D     = 8'h44;  // 'D'
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;  // ','
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;  // ':'
  localparam logic [BYTE_W-1:0] DIGIT_LO   = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] DIGIT_HI   = 8'h39;  // '9'

  localparam logic [PM_W-1:0] PM_DONE = 3'd5;

  // one parser result, registered in the top level
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] index;
    logic              last;
  } result_t;

  function automatic logic [BYTE_W-1:0] prefix_char(input logic [PM_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      3'd0:    c = CHAR_PLUS;
      3'd1:    c = CHAR_I;
      3'd2:    c = CHAR_P;
      3'd3:    c = CHAR_D;
      3'd4:    c = CHAR_COMMA;
      default: c = CHAR_PLUS;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/ipd_length_prefixed_frame_parser.sv -----
// Top level of the +IPD length-prefixed frame parser with its output register.
//
// Usage:
//   Input stream (s_axis_*): one received serial byte per item in tdata.
//   The parser hunts for "+IPD,", folds the decimal length that follows
//   (mod 256, ended by ':' or by any other non-digit, which is folded in
//   first), then forwards that many payload bytes and hunts again.
//   Output stream (m_axis_*): one item per payload byte; tdata carries the
//   byte and its index within the frame, tlast marks the final byte.
//   Prefix, length and terminator bytes produce no output item.
// An accepted payload byte is registered and then shown on m_axis.
// Throughput: one byte per clock unless stalled. The whole per-byte update
//   is a single pass through the parser state machine; the output register
//   decouples the sides, so a new byte is taken while the last result drains.
// Stall: when m_axis_tvalid is high and m_axis_tready low, s_axis_tready
//   drops and the held result stays stable until taken.
// Reset (rst, synchronous): parser returns to prefix hunt, counts clear,
//   the output register empties.
module ipd_length_prefixed_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_index
  output logic        m_axis_tlast    // last_byte
);

  ipd_pkg::result_t res;
  logic             take;

  logic                       out_valid;
  logic [ipd_pkg::BYTE_W-1:0] out_data;
  logic [ipd_pkg::BYTE_W-1:0] out_index;
  logic                       out_last;

  // output slot is free when empty or being drained this cycle
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  ipd_parse_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (s_axis_tdata),
    .res     (res)
  );

  // result register: valid is control, payload loads without reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res.valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      out_data  <= res.data;
      out_index <= res.index;
      out_last  <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_index, out_data};
  assign m_axis_tlast  = out_last;

endmodule

// ----- rtl/core/ipd_parse_fsm.sv -----
// Per-byte parser state machine: prefix hunt, length fold, payload pass.
module ipd_parse_fsm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,     // item accepted this cycle
  input  logic [ipd_pkg::BYTE_W-1:0]  rx_byte,
  output ipd_pkg::result_t            res       // valid only together with take
);

  logic [ipd_pkg::PHASE_W-1:0] phase, phase_next;
  logic [ipd_pkg::PM_W-1:0]    prefix_matched, prefix_matched_next;
  logic [ipd_pkg::BYTE_W-1:0]  frame_length, frame_length_next;
  logic [ipd_pkg::BYTE_W-1:0]  bytes_passed, bytes_passed_next;

  logic [ipd_pkg::PM_W-1:0]    pm_cur;
  logic [ipd_pkg::PM_W-1:0]    pm_inc;
  logic [ipd_pkg::BYTE_W-1:0]  len_fold;
  logic [ipd_pkg::BYTE_W-1:0]  idx_inc;
  logic                        is_digit;

  assign pm_cur   = (prefix_matched >= ipd_pkg::PM_DONE) ? '0 : prefix_matched;
  assign pm_inc   = pm_cur + 3'd1;
  // len*10 + b - '0', mod 256
  assign len_fold = (frame_length << 3) + (frame_length << 1) + rx_byte - ipd_pkg::DIGIT_LO;
  assign is_digit = (rx_byte >= ipd_pkg::DIGIT_LO) && (rx_byte <= ipd_pkg::DIGIT_HI);
  assign idx_inc  = bytes_passed + 8'd1;

  always_comb begin
    phase_next          = phase;
    prefix_matched_next = prefix_matched;
    frame_length_next   = frame_length;
    bytes_passed_next   = bytes_passed;
    res.valid = 1'b0;
    res.data  = rx_byte;
    res.index = bytes_passed;
    res.last  = (idx_inc == frame_length);
    if (take) begin
      unique case (phase)
        ipd_pkg::PH_LEN: begin
          if (rx_byte == ipd_pkg::CHAR_COLON) begin
            phase_next        = (frame_length == '0) ? ipd_pkg::PH_HUNT : ipd_pkg::PH_DATA;
            bytes_passed_next = '0;
          end else begin
            frame_length_next = len_fold;
            if (!is_digit) begin
              phase_next        = (len_fold == '0) ? ipd_pkg::PH_HUNT : ipd_pkg::PH_DATA;
              bytes_passed_next = '0;
            end
          end
        end
        ipd_pkg::PH_DATA: begin
          res.valid         = 1'b1;
          bytes_passed_next = idx_inc;
          if (idx_inc == frame_length) begin
            phase_next          = ipd_pkg::PH_HUNT;
            prefix_matched_next = '0;
          end
        end
        default: begin
          // hunting; unused code 3 hunts too
          phase_next = ipd_pkg::PH_HUNT;
          if (rx_byte == ipd_pkg::prefix_char(pm_cur)) begin
            if (pm_inc == ipd_pkg::PM_DONE) begin
              prefix_matched_next = '0;
              frame_length_next   = '0;
              bytes_passed_next   = '0;
              phase_next          = ipd_pkg::PH_LEN;
            end else begin
              prefix_matched_next = pm_inc;
            end
          end else begin
            // mismatch: the byte may start a new prefix
            prefix_matched_next = (rx_byte == ipd_pkg::CHAR_PLUS) ? 3'd1 : 3'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ipd_pkg::PH_HUNT;
      prefix_matched <= '0;
      frame_length   <= '0;
      bytes_passed   <= '0;
    end else begin
      phase          <= phase_next;
      prefix_matched <= prefix_matched_next;
      frame_length   <= frame_length_next;
      bytes_passed   <= bytes_passed_next;
    end
  end

endmodule

// ----- rtl/core/ipd_checker.sv -----
// Port-level checks for the frame parser, bound to the top level.
module ipd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // stalled item stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // empty output slot never blocks input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a new output item comes only from an accepted input item
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("output item without input item");

endmodule

bind ipd_length_prefixed_frame_parser ipd_checker u_ipd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- dv/ipd_length_prefixed_frame_parser_tb.sv -----
// Self-checking testbench for the +IPD length-prefixed frame parser.
module ipd_length_prefixed_frame_parser_tb;
  import ipd_pkg::*;

  // cycles with no item moved on either side before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET    = 2000;
  // the tail of the run goes without any idling
  localparam int unsigned CALM_TAIL      = 200;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam string       IPD_TEXT       = "+IPD,";

  // one payload item as seen on m_axis
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] index;
    logic              last;
  } payload_t;

  // Tracks the parser state byte by byte and holds the payload items it owes.
  class frame_scoreboard;
    localparam logic [8*PREFIX_LEN-1:0] PREFIX_BYTES =
      {CHAR_COMMA, CHAR_D, CHAR_P, CHAR_I, CHAR_PLUS};

    logic [PHASE_W-1:0] phase;
    logic [PM_W-1:0]    matched;
    logic [BYTE_W-1:0]  frame_len;
    logic [BYTE_W-1:0]  passed;
    payload_t           owed[$];
    int unsigned        n_errors;

    function new();
      phase     = PH_HUNT;
      matched   = '0;
      frame_len = '0;
      passed    = '0;
      n_errors  = 0;
    endfunction

    function void close_length();
      phase  = (frame_len == 0) ? PH_HUNT : PH_DATA;
      passed = '0;
    endfunction

    // Called for every byte the parser accepts.
    function void note_rx(logic [BYTE_W-1:0] b);
      payload_t p;
      if (phase == PH_LEN) begin
        if (b == CHAR_COLON) begin
          close_length();
        end else begin
          // any non-digit is still folded in before it ends the field
          frame_len = frame_len * 8'd10 + b - DIGIT_LO;
          if (b < DIGIT_LO || b > DIGIT_HI)
            close_length();
        end
      end else if (phase == PH_DATA) begin
        p.data  = b;
        p.index = passed;
        p.last  = (passed + 8'd1) == frame_len;
        owed.push_back(p);
        passed = passed + 8'd1;
        if (p.last) begin
          phase   = PH_HUNT;
          matched = '0;
        end
      end else begin
        phase = PH_HUNT;
        if (matched >= PREFIX_LEN)
          matched = '0;
        if (b == PREFIX_BYTES[8*matched +: 8]) begin
          matched = matched + 3'd1;
          if (matched == PM_DONE) begin
            matched   = '0;
            frame_len = '0;
            passed    = '0;
            phase     = PH_LEN;
          end
        end else begin
          // a mismatching '+' may open a new prefix
          matched = (b == CHAR_PLUS) ? 3'd1 : 3'd0;
        end
      end
    endfunction

    function void flag(string msg);
      if (n_errors < MAX_REPORTS)
        $display("[%0t] %s", $time, msg);
      n_errors++;
    endfunction

    // Called for every payload item the parser hands out.
    function void check_payload(logic [BYTE_W-1:0] data, logic [BYTE_W-1:0] index,
                                logic last);
      payload_t want;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected payload item data=%02h index=%0d last=%0b",
                       data, index, last));
        return;
      end
      want = owed.pop_front();
      if (data !== want.data)
        flag($sformatf("payload_byte: expected %02h, got %02h", want.data, data));
      if (index !== want.index)
        flag($sformatf("payload_index: expected %0d, got %0d", want.index, index));
      if (last !== want.last)
        flag($sformatf("last_byte: expected %0b, got %0b", want.last, last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  frame_scoreboard sb = new();

  int unsigned n_counted = 0;   // items that count toward the target
  int unsigned gap_pct   = 0;   // chance of a sender gap before an item
  int unsigned stall_pct = 0;   // chance of a receiver stall per cycle
  int unsigned quiet     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ipd_length_prefixed_frame_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result monitor: every payload item taken is checked against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_payload(m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
  end

  // Receiver back-pressure: stall bursts of random length.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offers one byte, with an optional gap first, and waits until it is taken.
  // tvalid stays high on return so back-to-back items are not split by an idle.
  task automatic send_byte(input logic [7:0] b, input bit counted = 1'b1);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_rx(b);
    if (counted)
      n_counted++;
  endtask

  task automatic send_text(input string s, input bit counted = 1'b1);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], counted);
  endtask

  // Stream payload bytes until the parser is back to hunting.
  task automatic drain_frame();
    while (sb.phase != PH_HUNT)
      send_byte(8'($urandom_range(0, 255)));
  endtask

  // One well-formed frame with random length and content; now and then
  // the length field ends on a non-digit instead of ':'.
  task automatic send_frame();
    int unsigned kind;
    int unsigned len_val;
    int unsigned term;
    string       digits;
    kind = $urandom_range(0, 99);
    if (kind < 2)
      len_val = $urandom_range(0, 1) ? 255 : $urandom_range(200, 254);
    else if (kind < 10)
      len_val = 0;
    else if (kind < 20)
      len_val = 256 * $urandom_range(1, 3) + $urandom_range(0, 12);   // wraps
    else
      len_val = $urandom_range(1, 16);
    digits = $sformatf("%0d", len_val);
    if ($urandom_range(0, 4) == 0)
      digits = {"0", digits};
    send_text(IPD_TEXT);
    send_text(digits);
    if ($urandom_range(0, 19) == 0) begin
      do term = $urandom_range(0, 255);
      while ((term >= DIGIT_LO && term <= DIGIT_HI) || term == CHAR_COLON);
      send_byte(term[7:0]);
    end else begin
      send_byte(CHAR_COLON);
    end
    drain_frame();
  endtask

  // Broken input: stray bytes or a prefix cut short by a wrong byte.
  task automatic send_noise();
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_text(IPD_TEXT.substr(0, $urandom_range(0, 3)), 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    // Prefix restart on a stray '+', one-byte frame carrying 0x00.
    send_text("+I+IPD,1:");
    send_byte(8'h00);
    // Length 256 wraps to zero: no payload at all.
    send_text("+IPD,256:");
    // Length field ended by '-': 26*10 + ('-' - '0') wraps to 1.
    send_text("+IPD,26-");
    send_byte(8'hFF);

    // Random part: mostly frames, some noise, idling varied per frame.
    while (n_counted < ITEM_TARGET) begin
      if (n_counted + CALM_TAIL >= ITEM_TARGET) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      end
      if ($urandom_range(0, 99) < 15)
        send_noise();
      drain_frame();   // noise may have opened a frame by chance
      send_frame();
    end
    s_axis_tvalid <= 1'b0;

    // Let the last payload items drain, then wait for strays.
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
